@@ design/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_ALLOC_WR,
    S_NEXT,
    S_MERGE
  } state_e;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
  localparam logic [1:0] STATUS_NULL_FREE = 2'd2;
  localparam logic [1:0] STATUS_BAD_ADDR  = 2'd3;

  // Configuration port: paddr width and register index of heap_base
  localparam int         PADDR_W       = 3;
  localparam logic [0:0] IDX_HEAP_BASE = 1'b0;

  // Width of offset and size arithmetic (offsets, sizes and header sum stay below 2^18)
  localparam int SUM_W = 18;

endpackage

@@ design/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/first_fit_heap_allocator.sv @@
// First-fit heap allocator with block splitting and free-block coalescing.
//
//   channel   handshake                          payload
//   request   start high while busy low          mode_i, request_size_i, free_address_i
//   result    done_o strobe, one cycle           payload_address_o, status_o
//   config    psel & penable & pwrite & pready   paddr, pwdata (heap_base at 0x0)
//
// Headers live in a RAM indexed by heap byte offset and are read one per cycle through
// its registered port; that walk sets the latency. An allocate walks to the first fit
// (then S_ALLOC_WR if it splits), a free walks until it finds or rejects its block and
// merges in S_NEXT and S_MERGE, and a null or out-of-range free reports from idle. After
// reset the block seeds the first header in S_INIT with busy high. The result receiver
// cannot stall; the next request may start in the cycle that shows the result.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 12,
  parameter int MIN_SPLIT    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [15:0]                 request_size_i,
  input  logic [31:0]                 free_address_i,
  // result
  output logic                        done_o,
  output logic [31:0]                 payload_address_o,
  output logic [1:0]                  status_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffha_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int OFF_W  = $clog2(HEAP_BYTES);
  localparam int SIZE_W = OFF_W;
  localparam int HDR_W  = SIZE_W + 1;
  localparam int SW     = ffha_pkg::SUM_W;

  localparam logic [SW-1:0]     HEAP_S    = SW'(HEAP_BYTES);
  localparam logic [SW-1:0]     HDR_S     = SW'(HEADER_BYTES);
  localparam logic [SW-1:0]     MIN_S     = SW'(MIN_SPLIT);
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [31:0]       HEAP_32   = 32'(HEAP_BYTES);
  localparam logic [31:0]       HDR_32    = 32'(HEADER_BYTES);

  ffha_pkg::state_e state_q, state_d;

  logic              mode_q, mode_d;
  logic [15:0]       req_q, req_d;
  logic [SW-1:0]     req_h_q, req_h_d;
  logic [SW-1:0]     req_split_q, req_split_d;
  logic [OFF_W-1:0]  target_q, target_d;
  logic [OFF_W-1:0]  cur_q, cur_d;
  logic [OFF_W-1:0]  prev_off_q, prev_off_d;
  logic              prev_free_q, prev_free_d;
  logic [SIZE_W-1:0] prev_size_q, prev_size_d;
  logic [OFF_W-1:0]  start_off_q, start_off_d;
  logic [SIZE_W-1:0] acc_q, acc_d;
  logic [SIZE_W-1:0] cur_size_q, cur_size_d;
  logic [31:0]       heap_base_q, heap_base_d;
  logic              done_q, done_d;
  logic [31:0]       payload_q, payload_d;
  logic [1:0]        status_q, status_d;

  logic              ram_we;
  logic [OFF_W-1:0]  ram_waddr;
  logic [HDR_W-1:0]  ram_wdata;
  logic [OFF_W-1:0]  ram_raddr;
  logic [HDR_W-1:0]  ram_rdata;

  logic              rd_free;
  logic [SW-1:0]     rd_size;
  logic [SW-1:0]     sum_a, sum_b, sum;
  logic [31:0]       target32;
  logic [31:0]       grant_addr;
  logic              accept;
  logic              cfg_wr;
  logic              fit, split, hit;

  // Header store: {free, payload size} per block start offset
  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_free = ram_rdata[HDR_W-1];
  assign rd_size = SW'(ram_rdata[SIZE_W-1:0]);

  // Shared offset unit: a + header + b
  assign sum = sum_a + HDR_S + sum_b;

  assign accept     = start && !busy;
  assign target32   = free_address_i - heap_base_q - HDR_32;
  assign grant_addr = heap_base_q + 32'(cur_q) + HDR_32;
  assign fit        = rd_free && (rd_size >= SW'(req_q));
  assign split      = rd_size >= req_split_q;
  assign hit        = cur_q == target_q;

  // Configuration port
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign heap_base_d = (cfg_wr && paddr[2] == ffha_pkg::IDX_HEAP_BASE) ? pwdata : heap_base_q;
  assign prdata      = (paddr[2] == ffha_pkg::IDX_HEAP_BASE) ? heap_base_q : 32'd0;

  // Sequencer: next state, header walk and RAM control
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    req_d       = req_q;
    req_h_d     = req_h_q;
    req_split_d = req_split_q;
    target_d    = target_q;
    cur_d       = cur_q;
    prev_off_d  = prev_off_q;
    prev_free_d = prev_free_q;
    prev_size_d = prev_size_q;
    start_off_d = start_off_q;
    acc_d       = acc_q;
    cur_size_d  = cur_size_q;
    done_d      = 1'b0;
    payload_d   = payload_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = '0;
    ram_raddr   = cur_q;
    sum_a       = SW'(cur_q);
    sum_b       = rd_size;

    case (state_q)
      ffha_pkg::S_INIT: begin
        // Seed one free block spanning the heap
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, INIT_SIZE};
        state_d   = ffha_pkg::S_IDLE;
      end

      ffha_pkg::S_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          mode_d      = mode_i;
          req_d       = request_size_i;
          req_h_d     = SW'(request_size_i) + HDR_S;
          req_split_d = SW'(request_size_i) + HDR_S + MIN_S;
          cur_d       = '0;
          prev_free_d = 1'b0;
          target_d    = target32[OFF_W-1:0];
          state_d     = ffha_pkg::S_EVAL;
          if (mode_i == ffha_pkg::MODE_FREE) begin
            if (free_address_i == 32'd0) begin
              done_d    = 1'b1;
              payload_d = 32'd0;
              status_d  = ffha_pkg::STATUS_NULL_FREE;
              state_d   = ffha_pkg::S_IDLE;
            end else if (target32 >= HEAP_32) begin
              done_d    = 1'b1;
              payload_d = 32'd0;
              status_d  = ffha_pkg::STATUS_BAD_ADDR;
              state_d   = ffha_pkg::S_IDLE;
            end
          end
        end
      end

      ffha_pkg::S_EVAL: begin
        if (mode_q == ffha_pkg::MODE_ALLOC) begin
          sum_b = fit ? SW'(req_q) : rd_size;
          if (fit) begin
            if (split) begin
              // Split the tail off as a new free block
              ram_we    = 1'b1;
              ram_waddr = sum[OFF_W-1:0];
              ram_wdata = {1'b1, SIZE_W'(rd_size - req_h_q)};
              state_d   = ffha_pkg::S_ALLOC_WR;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, rd_size[SIZE_W-1:0]};
              done_d    = 1'b1;
              payload_d = grant_addr;
              status_d  = ffha_pkg::STATUS_DONE;
              state_d   = ffha_pkg::S_IDLE;
            end
          end else if (sum >= HEAP_S) begin
            done_d    = 1'b1;
            payload_d = 32'd0;
            status_d  = ffha_pkg::STATUS_NO_FIT;
            state_d   = ffha_pkg::S_IDLE;
          end else begin
            // Advance to the next block
            cur_d     = sum[OFF_W-1:0];
            ram_raddr = sum[OFF_W-1:0];
          end
        end else begin
          if (hit) begin
            if (rd_free) begin
              done_d    = 1'b1;
              payload_d = 32'd0;
              status_d  = ffha_pkg::STATUS_BAD_ADDR;
              state_d   = ffha_pkg::S_IDLE;
            end else begin
              // Release the block, merging into a free predecessor
              cur_size_d = rd_size[SIZE_W-1:0];
              if (prev_free_q) begin
                sum_a       = SW'(prev_size_q);
                start_off_d = prev_off_q;
                acc_d       = SIZE_W'(sum);
              end else begin
                start_off_d = cur_q;
                acc_d       = rd_size[SIZE_W-1:0];
              end
              state_d = ffha_pkg::S_NEXT;
            end
          end else if (cur_q > target_q || sum >= HEAP_S) begin
            done_d    = 1'b1;
            payload_d = 32'd0;
            status_d  = ffha_pkg::STATUS_BAD_ADDR;
            state_d   = ffha_pkg::S_IDLE;
          end else begin
            prev_off_d  = cur_q;
            prev_free_d = rd_free;
            prev_size_d = rd_size[SIZE_W-1:0];
            cur_d       = sum[OFF_W-1:0];
            ram_raddr   = sum[OFF_W-1:0];
          end
        end
      end

      ffha_pkg::S_ALLOC_WR: begin
        // Shrink the granted block to the request
        ram_we    = 1'b1;
        ram_wdata = {1'b0, SIZE_W'(req_q)};
        done_d    = 1'b1;
        payload_d = grant_addr;
        status_d  = ffha_pkg::STATUS_DONE;
        state_d   = ffha_pkg::S_IDLE;
      end

      ffha_pkg::S_NEXT: begin
        sum_b = SW'(cur_size_q);
        if (sum >= HEAP_S) begin
          ram_we    = 1'b1;
          ram_waddr = start_off_q;
          ram_wdata = {1'b1, acc_q};
          done_d    = 1'b1;
          payload_d = 32'd0;
          status_d  = ffha_pkg::STATUS_DONE;
          state_d   = ffha_pkg::S_IDLE;
        end else begin
          ram_raddr = sum[OFF_W-1:0];
          state_d   = ffha_pkg::S_MERGE;
        end
      end

      ffha_pkg::S_MERGE: begin
        // Absorb a free successor, then write the merged header
        sum_a     = SW'(acc_q);
        ram_we    = 1'b1;
        ram_waddr = start_off_q;
        ram_wdata = {1'b1, rd_free ? SIZE_W'(sum) : acc_q};
        done_d    = 1'b1;
        payload_d = 32'd0;
        status_d  = ffha_pkg::STATUS_DONE;
        state_d   = ffha_pkg::S_IDLE;
      end

      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_INIT;
      done_q      <= 1'b0;
      heap_base_q <= 32'd0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      heap_base_q <= heap_base_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    req_q       <= req_d;
    req_h_q     <= req_h_d;
    req_split_q <= req_split_d;
    target_q    <= target_d;
    cur_q       <= cur_d;
    prev_off_q  <= prev_off_d;
    prev_free_q <= prev_free_d;
    prev_size_q <= prev_size_d;
    start_off_q <= start_off_d;
    acc_q       <= acc_d;
    cur_size_q  <= cur_size_d;
    payload_q   <= payload_d;
    status_q    <= status_d;
  end

  assign busy              = state_q != ffha_pkg::S_IDLE;
  assign done_o            = done_q;
  assign payload_address_o = payload_q;
  assign status_o          = status_q;

  // Results appear only once the sequencer is back at rest
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // An accepted request either starts a walk or reports at once
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted request produced neither walk nor result");

  // Headers change only during a walk or the reset seed
  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_IDLE) |-> !ram_we)
    else $error("header write while idle");

endmodule

@@ sim/first_fit_heap_allocator_test.sv @@
// Self-checking testbench for the first-fit heap allocator: directed table, then random traffic.
module first_fit_heap_allocator_test;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 12;
  localparam int MIN_SPLIT    = 4;
  localparam int NUM_ROWS     = 27;
  localparam int PHASE_ITEMS  = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [ffha_pkg::PADDR_W-1:0] HEAP_BASE_ADDR =
    ffha_pkg::PADDR_W'(4 * ffha_pkg::IDX_HEAP_BASE);

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
  } heap_result_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_e;

  // One table row: a request or a heap_base write (value in addr)
  typedef struct {
    row_kind_e   kind;
    logic        mode;
    logic [15:0] size;
    logic [31:0] addr;
    bit          typed;
    logic [31:0] want_addr;
    logic [1:0]  want_status;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = ffha_pkg::MODE_ALLOC;
  logic [15:0] request_size_i = '0;
  logic [31:0] free_address_i = '0;
  logic        done_o;
  logic [31:0] payload_address_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ffha_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow heap: header per byte offset
  bit          hdr_head [HEAP_BYTES];
  bit          hdr_free [HEAP_BYTES];
  int unsigned hdr_len  [HEAP_BYTES];
  logic [31:0] base_cfg;

  // Offsets of allocated blocks and of recently released ones (stimulus hints)
  int unsigned live_offs[$];
  int unsigned released_offs[$];

  heap_result_t due_results[$];
  int          fail_count = 0;
  int          next_gap = 0;
  bit          start_held = 1'b0;
  bit          burst = 1'b0;
  stim_row_t   plan [NUM_ROWS];

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MIN_SPLIT   (MIN_SPLIT)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .request_size_i   (request_size_i),
    .free_address_i   (free_address_i),
    .done_o           (done_o),
    .payload_address_o(payload_address_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Report the first few mismatches, count the rest
  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // Merge every run of adjacent free blocks, in address order
  function automatic void merge_free_runs();
    int unsigned cur;
    int unsigned nxt;
    cur = 0;
    while (cur < HEAP_BYTES) begin
      nxt = cur + HEADER_BYTES + hdr_len[cur];
      if (nxt >= HEAP_BYTES) begin
        cur = HEAP_BYTES;
      end else if (hdr_free[cur] && hdr_free[nxt]) begin
        hdr_len[cur]  = hdr_len[cur] + HEADER_BYTES + hdr_len[nxt];
        hdr_head[nxt] = 1'b0;
        hdr_free[nxt] = 1'b0;
        hdr_len[nxt]  = 0;
      end else begin
        cur = nxt;
      end
    end
  endfunction

  // Apply one request to the shadow heap and return the outcome it must give
  function automatic heap_result_t apply_heap_request(logic m, logic [15:0] sz, logic [31:0] fa);
    heap_result_t r;
    int unsigned  off;
    int unsigned  nb;
    bit           found;
    logic [31:0]  rel;
    r.addr   = '0;
    r.status = ffha_pkg::STATUS_DONE;
    if (m == ffha_pkg::MODE_ALLOC) begin
      off   = 0;
      found = 1'b0;
      while (off < HEAP_BYTES && !found) begin
        if (hdr_free[off] && hdr_len[off] >= sz) found = 1'b1;
        else off = off + HEADER_BYTES + hdr_len[off];
      end
      if (found) begin
        // Split off the tail when it can hold a header plus the minimum payload
        if (hdr_len[off] >= sz + HEADER_BYTES + MIN_SPLIT) begin
          nb = off + HEADER_BYTES + sz;
          if (nb < HEAP_BYTES) begin
            hdr_head[nb] = 1'b1;
            hdr_free[nb] = 1'b1;
            hdr_len[nb]  = hdr_len[off] - sz - HEADER_BYTES;
            hdr_len[off] = sz;
          end
        end
        hdr_free[off] = 1'b0;
        r.addr = base_cfg + 32'(off) + 32'(HEADER_BYTES);
        live_offs.push_back(off);
      end else begin
        r.status = ffha_pkg::STATUS_NO_FIT;
      end
    end else if (fa == '0) begin
      r.status = ffha_pkg::STATUS_NULL_FREE;
    end else begin
      rel = fa - base_cfg - 32'(HEADER_BYTES);
      if (rel < HEAP_BYTES && hdr_head[rel] && !hdr_free[rel]) begin
        hdr_free[rel] = 1'b1;
        merge_free_runs();
        for (int i = 0; i < live_offs.size(); i++) begin
          if (live_offs[i] == rel) begin
            live_offs.delete(i);
            break;
          end
        end
        released_offs.push_back(rel);
        if (released_offs.size() > 16) void'(released_offs.pop_front());
      end else begin
        r.status = ffha_pkg::STATUS_BAD_ADDR;
      end
    end
    return r;
  endfunction

  // Drive one request and wait for its transfer; typed rows carry their own expectation
  task automatic send_request(logic m, logic [15:0] sz, logic [31:0] fa,
                              bit typed, heap_result_t want);
    heap_result_t r;
    if (!start_held) begin
      repeat (next_gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= m;
    request_size_i <= sz;
    free_address_i <= fa;
    do @(posedge clk_i); while (busy);
    r = apply_heap_request(m, sz, fa);
    due_results.push_back(typed ? want : r);
    // Decide now whether the next request follows back to back
    next_gap   = burst ? 0 : $urandom_range(0, 4);
    start_held = (next_gap == 0);
    if (!start_held) start <= 1'b0;
  endtask

  // Drop start when it was held for a follow-on request
  task automatic park_request();
    if (start_held) begin
      start      <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // Write heap_base once the block is idle, then read it back
  task automatic write_heap_base(logic [31:0] value);
    logic [31:0] rb;
    park_request();
    wait (due_results.size() == 0);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HEAP_BASE_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    base_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rb = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rb !== value) flag_mismatch("heap_base readback", value, rb);
  endtask

  // Random traffic: mostly allocate/release of live blocks, some bad and null frees
  task automatic run_random_phase(int count);
    int unsigned  pick;
    logic         m;
    logic [15:0]  sz;
    logic [31:0]  fa;
    heap_result_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 63) == 0) burst = !burst;
      pick = $urandom_range(0, 99);
      if (live_offs.size() > 60 && pick < 45) pick = pick + 45;
      sz = '0;
      fa = '0;
      if (live_offs.size() == 0 || pick < 45) begin
        m    = ffha_pkg::MODE_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 70)      sz = 16'($urandom_range(0, 48));
        else if (pick < 90) sz = 16'($urandom_range(49, 600));
        else if (pick < 97) sz = 16'($urandom_range(601, HEAP_BYTES));
        else                sz = 16'($urandom);
      end else begin
        m = ffha_pkg::MODE_FREE;
        if (pick < 85) begin
          fa = base_cfg + live_offs[$urandom_range(0, live_offs.size() - 1)] + HEADER_BYTES;
        end else if (pick < 90 && released_offs.size() > 0) begin
          fa = base_cfg + released_offs[$urandom_range(0, released_offs.size() - 1)]
               + HEADER_BYTES;
        end else if (pick < 93) begin
          fa = base_cfg + live_offs[$urandom_range(0, live_offs.size() - 1)]
               + $urandom_range(1, HEADER_BYTES + 3);
        end else if (pick < 97) begin
          fa = $urandom;
        end
      end
      send_request(m, sz, fa, 1'b0, none);
    end
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin : check_results
    heap_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result address", '0, payload_address_o);
      end else begin
        want = due_results.pop_front();
        if (payload_address_o !== want.addr) begin
          flag_mismatch("payload_address", want.addr, payload_address_o);
        end
        if (status_o !== want.status) begin
          flag_mismatch("status", 32'(want.status), 32'(status_o));
        end
      end
    end
  end

  // Stimulus
  initial begin
    base_cfg = '0;
    for (int i = 0; i < HEAP_BYTES; i++) begin
      hdr_head[i] = 1'b0;
      hdr_free[i] = 1'b0;
      hdr_len[i]  = 0;
    end
    hdr_head[0] = 1'b1;
    hdr_free[0] = 1'b1;
    hdr_len[0]  = HEAP_BYTES - HEADER_BYTES;

    plan = '{
      // after reset: null free, oversize, free of a free block, out of range
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd0, 1'b1, 32'd0, ffha_pkg::STATUS_NULL_FREE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'hFFFF, 32'd0, 1'b1, 32'd0, ffha_pkg::STATUS_NO_FIT},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd4085, 32'd0, 1'b1, 32'd0, ffha_pkg::STATUS_NO_FIT},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b1, 32'd0, ffha_pkg::STATUS_BAD_ADDR},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'hFFFFFFFF, 1'b1, 32'd0, ffha_pkg::STATUS_BAD_ADDR},
      // exact fit of the whole heap, then nothing left even for size zero
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd4084, 32'd0, 1'b1, 32'd12, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd0, 32'd0, 1'b1, 32'd0, ffha_pkg::STATUS_NO_FIT},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b1, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b1, 32'd0, ffha_pkg::STATUS_BAD_ADDR},
      // split right at the threshold, then one byte short of it
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd4068, 32'd0, 1'b1, 32'd12, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd4, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd4092, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd4069, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      // zero-size blocks, free in the middle, misaligned free, merge
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd24, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd25, 1'b1, 32'd0, ffha_pkg::STATUS_BAD_ADDR},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd12, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd12, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      // top base: payload address wraps below the base
      '{ROW_CFG, ffha_pkg::MODE_ALLOC, 16'd0, 32'hFFFFFFFF, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd11, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      // base where the first payload address wraps to zero
      '{ROW_CFG, ffha_pkg::MODE_ALLOC, 16'd0, 32'hFFFFFFF4, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, ffha_pkg::STATUS_DONE},
      '{ROW_REQ, ffha_pkg::MODE_FREE, 16'd0, 32'd0, 1'b1, 32'd0, ffha_pkg::STATUS_NULL_FREE}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_heap_base(plan[i].addr);
      end else begin
        send_request(plan[i].mode, plan[i].size, plan[i].addr, plan[i].typed,
                     '{addr: plan[i].want_addr, status: plan[i].want_status});
      end
    end

    // Random phases, each under its own heap_base; every write drains the block first
    write_heap_base(32'd0);
    run_random_phase(PHASE_ITEMS);
    write_heap_base(32'hFFFF_FFFF);
    run_random_phase(PHASE_ITEMS);
    write_heap_base($urandom);
    run_random_phase(PHASE_ITEMS);
    write_heap_base(32'hFFFF_FFF4);
    run_random_phase(PHASE_ITEMS);
    write_heap_base(32'h8000_0000);
    run_random_phase(PHASE_ITEMS);
    write_heap_base($urandom);
    run_random_phase(PHASE_ITEMS);

    // Drain, then allow for a full list walk
    park_request();
    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
